>>> hdl/go_back_n_sender_window_macros.svh
// Assertion macros for the sender window checker
`ifndef GO_BACK_N_SENDER_WINDOW_MACROS_SVH
`define GO_BACK_N_SENDER_WINDOW_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define GBN_ASSERT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
	else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define GBN_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error(msg);

`endif

>>> hdl/gbn_pkg.sv
package gbn_pkg;

	localparam int unsigned PAYLOAD_BYTES = 512;
	localparam int unsigned PAY_SHIFT     = $clog2(PAYLOAD_BYTES);
	localparam int unsigned WINDOW_MAX    = 16;
	localparam int unsigned RESULT_LIMIT  = 16;
	localparam int unsigned WIN_LIMIT     = (WINDOW_MAX < RESULT_LIMIT) ? WINDOW_MAX : RESULT_LIMIT;

	localparam int unsigned SEQ_W   = 16;
	localparam int unsigned LEN_W   = 20;
	localparam int unsigned BYTES_W = 13;
	localparam int unsigned WIN_W   = 5;
	localparam int unsigned TMO_W   = 16;
	localparam int unsigned CNT_W   = 5;
	localparam int unsigned ADDR_W  = 3;
	localparam int unsigned DATA_W  = 32;

	localparam logic [WIN_W-1:0] WINDOW_RST  = 5'd4;
	localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd1000;

	localparam logic REG_WINDOW  = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;

	typedef enum logic [1:0] {
		FUNC_START = 2'd0,
		FUNC_ACK   = 2'd1,
		FUNC_TICK  = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		KIND_NEW    = 2'd0,
		KIND_RESEND = 2'd1,
		KIND_DONE   = 2'd2
	} kind_t;

	typedef struct packed {
		logic [WIN_W-1:0] window;
		logic [TMO_W-1:0] timeout;
	} cfg_t;

	typedef struct packed {
		kind_t              kind;
		logic [SEQ_W-1:0]   first;
		logic [CNT_W-1:0]   count;
		logic [SEQ_W-1:0]   end_seq;
		logic [BYTES_W-1:0] final_bytes;
	} cmd_t;

	typedef struct packed {
		logic push;
		cmd_t cmd;
	} q_wr_t;

endpackage

>>> hdl/gbn_front.sv
module gbn_front import gbn_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             evt_valid,
	output logic             evt_ready,
	input  logic [1:0]       func,
	input  logic [LEN_W-1:0] message_length,
	input  logic [SEQ_W-1:0] ack_seq,
	input  logic             q_full,
	output q_wr_t            q_wr
);

	logic [SEQ_W-1:0]   base_q, next_q, end_q, idle_q;
	logic [BYTES_W-1:0] final_q;
	logic               active_q;

	logic [SEQ_W-1:0]   base_d, next_d, end_d, idle_d;
	logic [BYTES_W-1:0] final_d;
	logic               active_d;

	logic [WIN_W-1:0]   eff_win;
	logic [LEN_W:0]     len_round;
	logic [LEN_W-1:0]   len_m1;
	logic [SEQ_W-1:0]   st_end;
	logic [BYTES_W-1:0] st_final;
	logic [CNT_W-1:0]   st_cnt;

	logic               ack_hit, ack_done;
	logic [SEQ_W-1:0]   ack_base;
	logic [SEQ_W:0]     lim_win, lim_end, lim;
	logic [CNT_W-1:0]   ack_cnt;

	logic [SEQ_W-1:0]   idle_inc;
	logic [TMO_W-1:0]   tmo;
	logic               expire;
	logic [CNT_W-1:0]   rs_cnt;

	logic               accept;

	assign evt_ready = !q_full;
	assign accept    = evt_valid && evt_ready;

	always_comb begin
		if (cfg.window == '0) begin
			eff_win = WIN_W'(1);
		end else if (cfg.window > WIN_W'(WIN_LIMIT)) begin
			eff_win = WIN_W'(WIN_LIMIT);
		end else begin
			eff_win = cfg.window;
		end
	end

	assign len_round = {1'b0, message_length} + (LEN_W+1)'(PAYLOAD_BYTES - 1);
	assign st_end    = SEQ_W'(len_round >> PAY_SHIFT) + SEQ_W'(1);
	assign len_m1    = message_length - LEN_W'(1);
	assign st_final  = (message_length == '0) ? '0
	                 : BYTES_W'(len_m1[PAY_SHIFT-1:0]) + BYTES_W'(1);
	assign st_cnt    = (st_end < SEQ_W'(eff_win)) ? CNT_W'(st_end) : CNT_W'(eff_win);

	assign ack_hit  = active_q && (ack_seq >= base_q) && (ack_seq < next_q);
	assign ack_done = ack_seq >= end_q;
	assign ack_base = ack_seq + SEQ_W'(1);
	assign lim_win  = {1'b0, ack_base} + (SEQ_W+1)'(eff_win);
	assign lim_end  = {1'b0, end_q} + (SEQ_W+1)'(1);
	assign lim      = (lim_win < lim_end) ? lim_win : lim_end;
	assign ack_cnt  = (lim > {1'b0, next_q}) ? CNT_W'(lim - {1'b0, next_q}) : '0;

	assign idle_inc = idle_q + SEQ_W'(1);
	assign tmo      = (cfg.timeout == '0) ? TMO_W'(1) : cfg.timeout;
	assign expire   = idle_inc >= tmo;
	assign rs_cnt   = CNT_W'(next_q - base_q);

	always_comb begin
		base_d   = base_q;
		next_d   = next_q;
		end_d    = end_q;
		final_d  = final_q;
		idle_d   = idle_q;
		active_d = active_q;

		q_wr.push            = 1'b0;
		q_wr.cmd.kind        = KIND_NEW;
		q_wr.cmd.first       = next_q;
		q_wr.cmd.count       = '0;
		q_wr.cmd.end_seq     = end_q;
		q_wr.cmd.final_bytes = final_q;

		if (accept) begin
			unique case (func)
				FUNC_START: begin
					end_d    = st_end;
					final_d  = st_final;
					base_d   = SEQ_W'(1);
					next_d   = SEQ_W'(1) + SEQ_W'(st_cnt);
					idle_d   = '0;
					active_d = 1'b1;

					q_wr.push            = 1'b1;
					q_wr.cmd.first       = SEQ_W'(1);
					q_wr.cmd.count       = st_cnt;
					q_wr.cmd.end_seq     = st_end;
					q_wr.cmd.final_bytes = st_final;
				end
				FUNC_ACK: begin
					if (ack_hit) begin
						base_d = ack_base;
						idle_d = '0;
						if (ack_done) begin
							active_d       = 1'b0;
							q_wr.push      = 1'b1;
							q_wr.cmd.kind  = KIND_DONE;
							q_wr.cmd.first = '0;
							q_wr.cmd.count = CNT_W'(1);
						end else begin
							next_d         = next_q + SEQ_W'(ack_cnt);
							q_wr.push      = ack_cnt != '0;
							q_wr.cmd.count = ack_cnt;
						end
					end
				end
				FUNC_TICK: begin
					if (active_q) begin
						idle_d = expire ? '0 : idle_inc;
						if (expire) begin
							q_wr.push      = rs_cnt != '0;
							q_wr.cmd.kind  = KIND_RESEND;
							q_wr.cmd.first = base_q;
							q_wr.cmd.count = rs_cnt;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= SEQ_W'(1);
			next_q   <= SEQ_W'(1);
			end_q    <= '0;
			final_q  <= '0;
			idle_q   <= '0;
			active_q <= 1'b0;
		end else begin
			base_q   <= base_d;
			next_q   <= next_d;
			end_q    <= end_d;
			final_q  <= final_d;
			idle_q   <= idle_d;
			active_q <= active_d;
		end
	end

endmodule

>>> hdl/gbn_queue.sv
module gbn_queue import gbn_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  q_wr_t wr,
	input  logic  pop,
	output logic  valid,
	output logic  full,
	output cmd_t  rd_cmd
);

	localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned FILL_W = $clog2(DEPTH + 1);

	cmd_t              entries_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              push_ok, pop_ok;

	assign valid   = fill_q != '0;
	assign full    = fill_q == FILL_W'(DEPTH);
	assign push_ok = wr.push && !full;
	assign pop_ok  = pop && valid;
	assign rd_cmd  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			entries_q[wr_ptr_q] <= wr.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push_ok, pop_ok})
				2'b10:   fill_q <= fill_q + FILL_W'(1);
				2'b01:   fill_q <= fill_q - FILL_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

>>> hdl/gbn_back.sv
module gbn_back import gbn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  cmd_t               q_cmd,
	output logic               pop,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [1:0]         kind,
	output logic [SEQ_W-1:0]   send_seq,
	output logic [BYTES_W-1:0] payload_bytes,
	output logic               is_end,
	output logic               last
);

	logic               have_q;
	kind_t              cur_kind_q;
	logic [SEQ_W-1:0]   seq_q, end_q;
	logic [CNT_W-1:0]   left_q;
	logic [BYTES_W-1:0] final_q;

	logic               res_valid_q;
	kind_t              kind_q;
	logic [SEQ_W-1:0]   send_seq_q;
	logic [BYTES_W-1:0] bytes_q;
	logic               is_end_q, last_q;

	logic               out_free, emit;
	logic [BYTES_W-1:0] w_bytes;
	logic               w_end;

	assign out_free = !res_valid_q || res_ready;
	assign pop      = !have_q && q_valid;
	assign emit     = have_q && out_free;

	always_comb begin
		if (cur_kind_q == KIND_DONE) begin
			w_bytes = '0;
			w_end   = 1'b0;
		end else if (seq_q == end_q) begin
			w_bytes = '0;
			w_end   = 1'b1;
		end else if (seq_q + SEQ_W'(1) == end_q) begin
			w_bytes = final_q;
			w_end   = 1'b0;
		end else begin
			w_bytes = BYTES_W'(PAYLOAD_BYTES);
			w_end   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q      <= 1'b0;
			left_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				have_q <= 1'b1;
				left_q <= q_cmd.count;
			end else if (emit) begin
				left_q <= left_q - CNT_W'(1);
				if (left_q == CNT_W'(1)) begin
					have_q <= 1'b0;
				end
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_kind_q <= q_cmd.kind;
			seq_q      <= q_cmd.first;
			end_q      <= q_cmd.end_seq;
			final_q    <= q_cmd.final_bytes;
		end else if (emit) begin
			seq_q <= seq_q + SEQ_W'(1);
		end
		if (emit) begin
			kind_q     <= cur_kind_q;
			send_seq_q <= seq_q;
			bytes_q    <= w_bytes;
			is_end_q   <= w_end;
			last_q     <= left_q == CNT_W'(1);
		end
	end

	assign res_valid     = res_valid_q;
	assign kind          = kind_q;
	assign send_seq      = send_seq_q;
	assign payload_bytes = bytes_q;
	assign is_end        = is_end_q;
	assign last          = last_q;

endmodule

>>> hdl/go_back_n_sender_window.sv
// Channel   Handshake            Word
// evt       evt_valid/evt_ready  func, message_length, ack_seq
// res       res_valid/res_ready  kind, send_seq, payload_bytes, is_end, last
// cfg       APB write/read       window at 0x0, timeout_ticks at 0x4
//
// An event word is taken while the command queue has room.
// A command's n words leave one per cycle unless res_ready stalls, then the next pops.
// res_ready low holds the output register; the queue then fills and drops evt_ready.
// Reset clears the window state and loads window 4, timeout 1000; no clearing pass.
module go_back_n_sender_window import gbn_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	input  logic               evt_valid,
	output logic               evt_ready,
	input  logic [1:0]         func,
	input  logic [LEN_W-1:0]   message_length,
	input  logic [SEQ_W-1:0]   ack_seq,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [1:0]         kind,
	output logic [SEQ_W-1:0]   send_seq,
	output logic [BYTES_W-1:0] payload_bytes,
	output logic               is_end,
	output logic               last
);

	cfg_t  cfg_q;
	q_wr_t q_wr;
	cmd_t  q_cmd;
	logic  q_full, q_valid, q_pop;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window  <= WINDOW_RST;
			cfg_q.timeout <= TIMEOUT_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_WINDOW:  cfg_q.window  <= pwdata[WIN_W-1:0];
				REG_TIMEOUT: cfg_q.timeout <= pwdata[TMO_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WINDOW:  prdata = DATA_W'(cfg_q.window);
			REG_TIMEOUT: prdata = DATA_W'(cfg_q.timeout);
		endcase
	end

	gbn_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.evt_valid      (evt_valid),
		.evt_ready      (evt_ready),
		.func           (func),
		.message_length (message_length),
		.ack_seq        (ack_seq),
		.q_full         (q_full),
		.q_wr           (q_wr)
	);

	gbn_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.pop    (q_pop),
		.valid  (q_valid),
		.full   (q_full),
		.rd_cmd (q_cmd)
	);

	gbn_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_cmd         (q_cmd),
		.pop           (q_pop),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.kind          (kind),
		.send_seq      (send_seq),
		.payload_bytes (payload_bytes),
		.is_end        (is_end),
		.last          (last)
	);

endmodule

>>> hdl/gbn_checker.sv
`include "go_back_n_sender_window_macros.svh"

module gbn_checker import gbn_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input logic [1:0]         kind,
	input logic [SEQ_W-1:0]   send_seq,
	input logic [BYTES_W-1:0] payload_bytes,
	input logic               is_end,
	input logic               last
);

	localparam logic [BYTES_W-1:0] MAX_BYTES = BYTES_W'(PAYLOAD_BYTES);

	logic [SEQ_W+BYTES_W+3:0] res_word;
	logic                     res_stall, done_word, end_word, pkt_word;

	assign res_word  = {kind, send_seq, payload_bytes, is_end, last};
	assign res_stall = res_valid && !res_ready;
	assign done_word = res_valid && kind == KIND_DONE;
	assign end_word  = res_valid && is_end;
	assign pkt_word  = res_valid && kind != KIND_DONE;

	`GBN_ASSERT_NEXT(a_res_hold, res_stall, res_valid && $stable(res_word), "stalled word moved")

	`GBN_ASSERT(a_done_word, done_word, {send_seq, payload_bytes, is_end} == '0 && last, "bad done")

	`GBN_ASSERT(a_end_word, end_word, payload_bytes == '0 && last && kind != KIND_DONE, "bad end")

	`GBN_ASSERT(a_packet_word, pkt_word, send_seq != '0 && payload_bytes <= MAX_BYTES, "bad packet")

endmodule

bind go_back_n_sender_window gbn_checker u_gbn_checker (.*);
